### rtl/core/quadtree_uniform_block_counter_macros.svh
// Assertion macros shared by the quadtree block counter RTL.
`ifndef QUADTREE_UNIFORM_BLOCK_COUNTER_MACROS_SVH
`define QUADTREE_UNIFORM_BLOCK_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QUBC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qubc assertion failed");

// Next-cycle implication, disabled during reset.
`define QUBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qubc assertion failed");

`endif

### rtl/core/qubc_pkg.sv
// Shared types and constants of the quadtree block counter.
package qubc_pkg;

   localparam int COUNT_W = 15;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_MERGE,
      ST_DONE
   } state_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic last;
      logic pixel;
   } pixel_entry_type;

   // Status of a finished block: mixed, or uniform with the given color.
   typedef struct packed {
      logic mixed;
      logic color;
   } blk_status_type;

endpackage

### rtl/core/qubc_front.sv
// Front end: side register, load position and last-pixel detection.
module qubc_front #(
   parameter int MAX_SIDE_LOG2 = 7,
   parameter int ADDR_W = 2 * MAX_SIDE_LOG2,
   parameter int LG_W = $clog2(MAX_SIDE_LOG2 + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [2:0]                csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_pixel,
   output logic [LG_W-1:0]           lg,
   output logic                      push_valid,
   input  logic                      push_ready,
   output logic [ADDR_W-1:0]         push_addr,
   output qubc_pkg::pixel_entry_type push_entry
);

   logic [2:0]        side_ff, side_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [3:0]        side_ext;
   logic [3:0]        max_ext;
   logic [3:0]        used_ext;
   logic [ADDR_W-1:0] last_pos;
   logic              is_last;

   always_comb begin
      side_ext = {1'b0, side_ff};
      max_ext  = 4'(MAX_SIDE_LOG2);
      used_ext = (side_ext > max_ext) ? max_ext : side_ext;
      lg       = used_ext[LG_W-1:0];
      last_pos = ~({ADDR_W{1'b1}} << {lg, 1'b0});
      is_last  = (pos_ff == last_pos);
   end

   assign req_ready        = push_ready;
   assign push_valid       = req_valid;
   assign push_addr        = pos_ff;
   assign push_entry.last  = is_last;
   assign push_entry.pixel = req_pixel;

   always_comb begin
      side_in = side_ff;
      pos_in  = pos_ff;
      if (csr_wen) begin
         side_in = csr_wdata;
         pos_in  = '0;
      end else if (req_valid && push_ready) begin
         pos_in = is_last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 3'd7;
         pos_ff  <= '0;
      end else begin
         side_ff <= side_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

### rtl/core/qubc_queue.sv
// Two-entry queue between the front end and the decomposition engine.
module qubc_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = data_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/qubc_back.sv
// Back end: image store and bottom-up quadtree merge in Z order.
`include "quadtree_uniform_block_counter_macros.svh"

module qubc_back #(
   parameter int MAX_SIDE_LOG2 = 7,
   parameter int ADDR_W = 2 * MAX_SIDE_LOG2,
   parameter int LG_W = $clog2(MAX_SIDE_LOG2 + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [LG_W-1:0]                lg,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic [ADDR_W-1:0]              pop_addr,
   input  qubc_pkg::pixel_entry_type      pop_entry,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [qubc_pkg::COUNT_W-1:0]   rsp_white,
   output logic [qubc_pkg::COUNT_W-1:0]   rsp_blue
);

   localparam int DEPTH = 1 << ADDR_W;
   localparam int LVL_W = (MAX_SIDE_LOG2 > 1) ? $clog2(MAX_SIDE_LOG2) : 1;
   localparam int CW    = qubc_pkg::COUNT_W;

   logic                      mem [DEPTH];
   logic                      q_ff;

   qubc_pkg::state_type       state_ff, state_in;
   logic [ADDR_W-1:0]         m_ff, m_in;
   logic [LG_W-1:0]           lvl_ff, lvl_in;
   qubc_pkg::blk_status_type  carry_ff, carry_in;
   logic [1:0]                n_ff [MAX_SIDE_LOG2];
   logic [1:0]                n_in [MAX_SIDE_LOG2];
   logic [1:0]                w_ff [MAX_SIDE_LOG2];
   logic [1:0]                w_in [MAX_SIDE_LOG2];
   logic [1:0]                b_ff [MAX_SIDE_LOG2];
   logic [1:0]                b_in [MAX_SIDE_LOG2];
   logic [CW-1:0]             white_ff, white_in;
   logic [CW-1:0]             blue_ff, blue_in;
   logic                      out_valid_ff, out_valid_in;
   logic [CW-1:0]             out_white_ff, out_white_in;
   logic [CW-1:0]             out_blue_ff, out_blue_in;

   logic                      do_pop;
   logic                      out_free;
   logic                      at_top;
   logic                      fourth;
   logic [MAX_SIDE_LOG2-1:0]  row;
   logic [MAX_SIDE_LOG2-1:0]  col;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ADDR_W-1:0]         m_mask;
   logic [LVL_W-1:0]          idx;
   qubc_pkg::blk_status_type  cur;
   logic                      cw;
   logic                      cb;
   logic [2:0]                w4;
   logic [2:0]                b4;

   assign pop_ready = (state_ff == qubc_pkg::ST_LOAD);
   assign do_pop    = pop_valid && pop_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_white = out_white_ff;
   assign rsp_blue  = out_blue_ff;

   // Z-order index to row-major address: odd bits give the row, even the column.
   always_comb begin
      for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
         row[i] = m_ff[2*i+1];
         col[i] = m_ff[2*i];
      end
      rd_addr = (ADDR_W'(row) << lg) | ADDR_W'(col);
      m_mask  = ~({ADDR_W{1'b1}} << {lg, 1'b0});
   end

   always_comb begin
      idx    = lvl_ff[LVL_W-1:0];
      cur    = (lvl_ff == '0) ? qubc_pkg::blk_status_type'{mixed: 1'b0, color: q_ff}
                              : carry_ff;
      cw     = !cur.mixed && !cur.color;
      cb     = !cur.mixed && cur.color;
      at_top = (lvl_ff == lg);
      fourth = (n_ff[idx] == 2'd3);
      w4     = {1'b0, w_ff[idx]} + {2'b00, cw};
      b4     = {1'b0, b_ff[idx]} + {2'b00, cb};
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         mem[pop_addr] <= pop_entry.pixel;
      end
      q_ff <= mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qubc_pkg::ST_LOAD: begin
            if (do_pop && pop_entry.last) begin
               state_in = qubc_pkg::ST_READ;
            end
         end
         qubc_pkg::ST_READ: begin
            state_in = qubc_pkg::ST_MERGE;
         end
         qubc_pkg::ST_MERGE: begin
            if (at_top) begin
               state_in = qubc_pkg::ST_DONE;
            end else if (!fourth) begin
               state_in = qubc_pkg::ST_READ;
            end
         end
         qubc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = qubc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = qubc_pkg::ST_LOAD;
         end
      endcase
   end

   // Datapath updates.
   always_comb begin
      m_in         = m_ff;
      lvl_in       = lvl_ff;
      carry_in     = carry_ff;
      n_in         = n_ff;
      w_in         = w_ff;
      b_in         = b_ff;
      white_in     = white_ff;
      blue_in      = blue_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_white_in = out_white_ff;
      out_blue_in  = out_blue_ff;
      case (state_ff)
         qubc_pkg::ST_LOAD: begin
            if (do_pop && pop_entry.last) begin
               m_in     = '0;
               lvl_in   = '0;
               white_in = '0;
               blue_in  = '0;
               for (int l = 0; l < MAX_SIDE_LOG2; l++) begin
                  n_in[l] = '0;
                  w_in[l] = '0;
                  b_in[l] = '0;
               end
            end
         end
         qubc_pkg::ST_READ: begin
            lvl_in = '0;
         end
         qubc_pkg::ST_MERGE: begin
            if (at_top) begin
               white_in = white_ff + CW'(cw);
               blue_in  = blue_ff + CW'(cb);
            end else if (!fourth) begin
               // Park this child in its parent and fetch the next pixel.
               n_in[idx] = n_ff[idx] + 2'd1;
               w_in[idx] = w_ff[idx] + {1'b0, cw};
               b_in[idx] = b_ff[idx] + {1'b0, cb};
               m_in      = m_ff + 1'b1;
            end else begin
               // Parent complete: collapse if uniform, else count its uniform children.
               n_in[idx] = '0;
               w_in[idx] = '0;
               b_in[idx] = '0;
               lvl_in    = lvl_ff + 1'b1;
               if (w4 == 3'd4) begin
                  carry_in = '{mixed: 1'b0, color: 1'b0};
               end else if (b4 == 3'd4) begin
                  carry_in = '{mixed: 1'b0, color: 1'b1};
               end else begin
                  carry_in = '{mixed: 1'b1, color: 1'b0};
                  white_in = white_ff + CW'(w4);
                  blue_in  = blue_ff + CW'(b4);
               end
            end
         end
         qubc_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_white_in = white_ff;
               out_blue_in  = blue_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      carry_ff     <= carry_in;
      w_ff         <= w_in;
      b_ff         <= b_in;
      white_ff     <= white_in;
      blue_ff      <= blue_in;
      out_white_ff <= out_white_in;
      out_blue_ff  <= out_blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qubc_pkg::ST_LOAD;
         lvl_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int l = 0; l < MAX_SIDE_LOG2; l++) begin
            n_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         out_valid_ff <= out_valid_in;
         n_ff         <= n_in;
      end
   end

   `QUBC_ASSERT_NOW(a_lvl_in_range, clock, reset, state_ff == qubc_pkg::ST_MERGE, lvl_ff <= lg)
   `QUBC_ASSERT_NOW(a_m_in_image, clock, reset, state_ff == qubc_pkg::ST_READ, (m_ff & ~m_mask) == '0)
   `QUBC_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == qubc_pkg::ST_DONE && out_free, out_valid_ff && state_ff == qubc_pkg::ST_LOAD)

endmodule

### rtl/core/quadtree_uniform_block_counter.sv
// Pixels load one per cycle while the engine is in its load state; after the last one the
// engine walks the image in Z order, with a store read and a merge step per pixel visited
// and a merge step per completed quadrant.
// The result then loads into the output register once it is free; pixels
// of the next image queue meanwhile (two entries) and then stall until the result loads.
// Synchronous active-high reset clears control state; side_log2 resets to 7.
module quadtree_uniform_block_counter #(
   parameter int MAX_SIDE_LOG2 = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [14:0] white_count, [29:15] blue_count
);

   localparam int ADDR_W = 2 * MAX_SIDE_LOG2;
   localparam int LG_W   = $clog2(MAX_SIDE_LOG2 + 1);
   localparam int ENT_W  = ADDR_W + $bits(qubc_pkg::pixel_entry_type);
   localparam int CW     = qubc_pkg::COUNT_W;

   logic                      push_valid;
   logic                      push_ready;
   logic [ADDR_W-1:0]         push_addr;
   qubc_pkg::pixel_entry_type push_entry;
   logic                      pop_valid;
   logic                      pop_ready;
   logic [ENT_W-1:0]          pop_data;
   logic [LG_W-1:0]           lg;
   logic [CW-1:0]             white;
   logic [CW-1:0]             blue;

   qubc_front #(
      .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
      .ADDR_W        (ADDR_W),
      .LG_W          (LG_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_pixel  (req_tdata[0]),
      .lg         (lg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_addr  (push_addr),
      .push_entry (push_entry)
   );

   qubc_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_addr, push_entry}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   qubc_back #(
      .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
      .ADDR_W        (ADDR_W),
      .LG_W          (LG_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .lg        (lg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_addr  (pop_data[ENT_W-1:ENT_W-ADDR_W]),
      .pop_entry (qubc_pkg::pixel_entry_type'(pop_data[ENT_W-ADDR_W-1:0])),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_white (white),
      .rsp_blue  (blue)
   );

   assign rsp_tdata = {2'b00, blue, white};

endmodule

### bench/block_count_checker.sv
// Checker for the quadtree block counter: predicts block counts per image and compares.
`timescale 1ns / 100ps

module block_count_checker #(
   parameter int MAX_SIDE_LOG2 = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pixel
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [14:0] white_count, [29:15] blue_count
   output int          fail_count,
   output int          outstanding,
   output int          results_checked
);

   localparam int DEPTH = 1 << (2 * MAX_SIDE_LOG2);
   localparam logic COLOR_BLUE = 1'b1;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic [qubc_pkg::COUNT_W-1:0] blue;
      logic [qubc_pkg::COUNT_W-1:0] white;
   } count_pair_type;

   logic                     image_bits [0:DEPTH-1];
   qubc_pkg::blk_status_type tile       [0:DEPTH-1];
   count_pair_type expected_counts [$];
   count_pair_type seen;
   count_pair_type want;
   logic [2:0]     side_log2 = 3'd7;
   int             load_pos = 0;
   int             fails = 0;
   int             checked = 0;
   int             lg;

   // Merge bottom up: each block's status sits at its top-left corner.
   // A mixed block counts every uniform quadrant it holds.
   function automatic count_pair_type count_uniform_blocks(input int img_lg);
      int                       side, lvl, step, half, r, c, k, base;
      qubc_pkg::blk_status_type quad [4];
      count_pair_type           tally;
      side = 1 << img_lg;
      for (k = 0; k < side * side; k++) begin
         tile[k] = '{mixed: 1'b0, color: image_bits[k]};
      end
      tally = '0;
      for (lvl = 1; lvl <= img_lg; lvl++) begin
         step = 1 << lvl;
         half = step >> 1;
         for (r = 0; r < side; r += step) begin
            for (c = 0; c < side; c += step) begin
               base = (r << img_lg) + c;
               quad[0] = tile[base];
               quad[1] = tile[base + (half << img_lg)];
               quad[2] = tile[base + half];
               quad[3] = tile[base + (half << img_lg) + half];
               if (quad[0].mixed || quad[1] != quad[0] || quad[2] != quad[0] ||
                   quad[3] != quad[0]) begin
                  for (k = 0; k < 4; k++) begin
                     if (!quad[k].mixed) begin
                        if (quad[k].color == COLOR_BLUE) tally.blue = tally.blue + 1'b1;
                        else tally.white = tally.white + 1'b1;
                     end
                  end
                  tile[base] = '{mixed: 1'b1, color: 1'b0};
               end
            end
         end
      end
      if (!tile[0].mixed) begin
         if (tile[0].color == COLOR_BLUE) tally.blue = tally.blue + 1'b1;
         else tally.white = tally.white + 1'b1;
      end
      return tally;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         side_log2 = 3'd7;
         load_pos = 0;
         expected_counts.delete();
      end else begin
         if (csr_wen) begin
            side_log2 = csr_wdata;
            load_pos = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[2*qubc_pkg::COUNT_W-1:0];
            if (expected_counts.size() == 0) begin
               fails++;
               if (fails <= SHOW_LIMIT)
                  $display("unexpected result: white %0d blue %0d", seen.white, seen.blue);
            end else begin
               want = expected_counts.pop_front();
               checked++;
               if (seen.white != want.white || seen.blue != want.blue) begin
                  fails++;
                  if (fails <= SHOW_LIMIT)
                     $display("count mismatch: white exp %0d got %0d, blue exp %0d got %0d",
                              want.white, seen.white, want.blue, seen.blue);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lg = (side_log2 > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : int'(side_log2);
            image_bits[load_pos] = req_tdata[0];
            if (load_pos < (1 << (2 * lg)) - 1) begin
               load_pos++;
            end else begin
               // last pixel of the image: decompose it
               load_pos = 0;
               expected_counts.push_back(count_uniform_blocks(lg));
            end
         end
      end
      fail_count <= fails;
      outstanding <= expected_counts.size();
      results_checked <= checked;
   end

endmodule

### bench/testbench.sv
// Top of the quadtree block counter bench: clock, reset, image stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_SIDE_LOG2 = 7;
   localparam int IDLE_LIMIT = 200000;
   localparam int PHASES = 10;

   typedef enum int {FILL_FLAT, FILL_BLOCKS, FILL_NOISY, FILL_RANDOM} fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [0] pixel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [14:0] white_count, [29:15] blue_count

   int   fail_count, outstanding, results_checked;
   int   burst_left = 0;
   int   pixels_sent = 0;
   int   writes = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   bit   bursty = 1'b1;
   bit   stall_on = 1'b1;
   logic [2:0] cur_lg = 3'd7;

   int phase_lg    [PHASES] = '{1, 2, 0, 3, 7, 4, 6, 5, 1, 2};
   int phase_count [PHASES] = '{40, 12, 30, 4, 0, 2, 0, 0, 20, 8};

   quadtree_uniform_block_counter #(.MAX_SIDE_LOG2(MAX_SIDE_LOG2)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   block_count_checker #(.MAX_SIDE_LOG2(MAX_SIDE_LOG2)) count_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: ready most of the time, with stall windows of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 29);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic pix);
      int gap;
      if (burst_left == 0) begin
         gap = bursty ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, pix};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      pixels_sent++;
   endtask

   // Drop valid, drain all pending results, then cover one full walk of the current side.
   task automatic quiesce;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * (1 << (2 * cur_lg)) + (1 << (2 * cur_lg)) / 3 + 16) @(posedge clock);
   endtask

   task automatic set_side(input logic [2:0] lg);
      quiesce();
      csr_wen <= 1'b1;
      csr_wdata <= lg;
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_lg = lg;
      writes++;
   endtask

   task automatic send_image(input int lg);
      int          side, g, i, r, c, pick;
      logic [31:0] salt, key;
      logic        pix, flat;
      fill_type    fill;
      side = 1 << lg;
      pick = $urandom_range(0, 9);
      fill = (pick == 0) ? FILL_FLAT : (pick <= 5) ? FILL_BLOCKS :
             (pick <= 7) ? FILL_NOISY : FILL_RANDOM;
      g = $urandom_range(0, lg);
      salt = $urandom;
      flat = 1'($urandom_range(0, 1));
      for (i = 0; i < side * side; i++) begin
         r = i >> lg;
         c = i & (side - 1);
         // hash the coarse block coordinates so blocks of side 2^g come out uniform
         key = ((((r >> g) << 8) ^ (c >> g)) ^ salt) * 32'h9E3779B1;
         case (fill)
            FILL_FLAT:   pix = flat;
            FILL_BLOCKS: pix = key[31];
            FILL_NOISY:  pix = key[31] ^ ($urandom_range(0, 63) == 0);
            default:     pix = 1'($urandom_range(0, 1));
         endcase
         send_pixel(pix);
      end
   endtask

   initial begin
      int p, k, n, lim;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single-pixel images
      set_side(3'd0);
      send_pixel(1'b0);
      send_pixel(1'b1);
      // 2x2 images: all white, all blue, mixed both ways
      set_side(3'd1);
      repeat (4) send_pixel(1'b0);
      repeat (4) send_pixel(1'b1);
      send_pixel(1'b0); send_pixel(1'b1); send_pixel(1'b0); send_pixel(1'b1);
      send_pixel(1'b1); send_pixel(1'b0); send_pixel(1'b0); send_pixel(1'b0);
      // leave an image unfinished; the next side write discards it unless the first phase's random pixels complete it
      send_pixel(1'b1); send_pixel(1'b0); send_pixel(1'b1);

      for (p = 0; p < PHASES; p++) begin
         if (cur_lg >= 1 && $urandom_range(0, 1) == 1) begin
            lim = (1 << (2 * cur_lg)) - 1;
            if (lim > 40) lim = 40;
            n = $urandom_range(1, lim);
            for (k = 0; k < n; k++) send_pixel(1'($urandom_range(0, 1)));
         end
         set_side(3'(phase_lg[p]));
         bursty = ($urandom_range(0, 3) != 0);
         stall_on <= ($urandom_range(0, 3) != 0);
         for (k = 0; k < phase_count[p]; k++) send_image(phase_lg[p]);
      end

      quiesce();
      $display("Checked %0d decomposition results from %0d pixels, full images of side 1 to 16",
               results_checked, pixels_sent);
      $display("%0d side register writes, some landing in the middle of an image", writes);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### quadtree_uniform_block_counter.f
+incdir+rtl/core
rtl/core/qubc_pkg.sv
rtl/core/qubc_front.sv
rtl/core/qubc_queue.sv
rtl/core/qubc_back.sv
rtl/core/quadtree_uniform_block_counter.sv
bench/block_count_checker.sv
bench/testbench.sv
